// ----- rtl/core/lcdw_pkg.sv -----
package lcdw_pkg;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_START = 2'd1,
		ACT_CMD   = 2'd2,
		ACT_DATA  = 2'd3
	} action_t;

	// register indexes on the configuration channel
	localparam logic [1:0] REG_TICKS_PER_US = 2'd0;
	localparam logic [1:0] REG_ENABLE_HIGH  = 2'd1;
	localparam logic [1:0] REG_WRITE_WAIT   = 2'd2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam int WAIT_W     = 14;

	localparam logic [7:0] TICKS_PER_US_RST = 8'd40;
	localparam logic [7:0] ENABLE_HIGH_RST  = 8'd10;
	localparam logic [9:0] WRITE_WAIT_RST   = 10'd40;

	localparam logic [WAIT_W-1:0] POWERUP_US = 14'd15000;
	localparam logic [2:0]        INIT_CMDS  = 3'd6;

	localparam logic [7:0] CMD_FUNC_SET  = 8'h38;
	localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
	localparam logic [7:0] CMD_ENTRY_MOD = 8'h06;

	// depth of the queues on either side of the engine
	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		action_t    act;
		logic [7:0] byte_val;
	} item_t;

	typedef struct packed {
		logic       rs;
		logic       rw;
		logic       en;
		logic [7:0] data;
		logic       busy;
		logic       rejected;
	} result_t;

	// power-up command sequence; an out-of-range step falls back to the first
	function automatic logic [7:0] init_cmd(input logic [2:0] step);
		logic [7:0] cmd;
		case (step)
			3'd0, 3'd1, 3'd2, 3'd3: cmd = CMD_FUNC_SET;
			3'd4:                   cmd = CMD_DISP_ON;
			3'd5:                   cmd = CMD_ENTRY_MOD;
			default:                cmd = CMD_FUNC_SET;
		endcase
		return cmd;
	endfunction

	// wait in microseconds after each power-up command
	function automatic logic [WAIT_W-1:0] init_wait(input logic [2:0] step);
		logic [WAIT_W-1:0] us;
		case (step)
			3'd0:    us = 14'd5000;
			3'd1:    us = 14'd100;
			3'd2, 3'd3, 3'd4, 3'd5: us = 14'd40;
			default: us = 14'd5000;
		endcase
		return us;
	endfunction

endpackage

// ----- rtl/core/char_lcd_init_and_write_controller.sv -----
// channel   handshake            payload
// input     push / full          action, byte_value
// result    empty / pop          rs_pin, rw_pin, enable_pin, data_pins, busy_res, rejected
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word per cycle while the result queue is not full: the engine updates the bus state once per word.
// A result reaches the result ports once its word has passed the input queue and then the
// result queue, both registered; a full result queue holds the word in the input queue.
// Both queues hold two words; full rises only after pop stays low long enough to fill both.
// arst_n clears the queues, the bus state and loads the register defaults; no clearing pass.
// cfg_ready is always high; writes to an index past the register list are dropped.
module char_lcd_init_and_write_controller import lcdw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [1:0]            action,
	input  logic [7:0]            byte_value,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  empty,
	input  logic                  pop,
	output logic                  rs_pin,
	output logic                  rw_pin,
	output logic                  enable_pin,
	output logic [7:0]            data_pins,
	output logic                  busy_res,
	output logic                  rejected
);

	logic    item_valid;
	logic    item_pop;
	item_t   item;
	logic    res_push;
	logic    res_full;
	result_t res_in;
	result_t res_out;

	assign cfg_ready = 1'b1;

	lcdw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.action     (action),
		.byte_value (byte_value),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.item       (item)
	);

	lcdw_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res_in)
	);

	lcdw_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res_in),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.res_out  (res_out)
	);

	assign rs_pin     = res_out.rs;
	assign rw_pin     = res_out.rw;
	assign enable_pin = res_out.en;
	assign data_pins  = res_out.data;
	assign busy_res   = res_out.busy;
	assign rejected   = res_out.rejected;

endmodule

// ----- rtl/core/lcdw_front.sv -----
module lcdw_front import lcdw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] action,
	input  logic [7:0] byte_value,
	output logic       item_valid,
	input  logic       item_pop,
	output item_t      item
);

	item_t            q_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	item_t            in_item;
	logic             do_push;
	logic             do_pop;

	// classify: only writes carry a byte
	always_comb begin
		in_item.act = action_t'(action);
		if (in_item.act == ACT_CMD || in_item.act == ACT_DATA) begin
			in_item.byte_val = byte_value;
		end else begin
			in_item.byte_val = '0;
		end
	end

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign item_valid = (count_q != '0);
	assign item       = q_mem[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = item_pop && item_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/lcdw_engine.sv -----
module lcdw_engine import lcdw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  item_valid,
	input  item_t                 item,
	output logic                  item_pop,
	input  logic                  res_full,
	output logic                  res_push,
	output result_t               res
);

	typedef enum logic [2:0] {
		PH_UNINIT      = 3'd0,
		PH_READY       = 3'd1,
		PH_POWERUP     = 3'd2,
		PH_STROBE      = 3'd3,
		PH_SETTLE      = 3'd4,
		PH_INIT_STROBE = 3'd5,
		PH_INIT_SETTLE = 3'd6
	} phase_t;

	logic [7:0]        tpu_q;
	logic [7:0]        eht_q;
	logic [9:0]        wwu_q;
	logic [7:0]        tpu_eff;
	logic [7:0]        eht_eff;
	logic [9:0]        wwu_eff;

	phase_t            phase_q, phase_n;
	logic [2:0]        step_q, step_n;
	logic [7:0]        pre_q, pre_n;
	logic [WAIT_W-1:0] wait_q, wait_n;
	logic [7:0]        bus_q, bus_n;
	logic              sel_q, sel_n;
	logic              rw_q, rw_n;
	logic              rej;

	logic              fire;
	logic              idle;
	logic [7:0]        pre_inc;
	logic              us_tick;
	logic [WAIT_W-1:0] wait_dec;
	logic [7:0]        cu_pre;
	logic [WAIT_W-1:0] cu_wait;
	logic              cu_done;
	logic [2:0]        step_inc;

	assign tpu_eff = (tpu_q == '0) ? 8'd1 : tpu_q;
	assign eht_eff = (eht_q == '0) ? 8'd1 : eht_q;
	assign wwu_eff = (wwu_q == '0) ? 10'd1 : wwu_q;

	assign fire     = item_valid && !res_full;
	assign item_pop = fire;
	assign res_push = fire;
	assign idle     = (phase_q == PH_UNINIT) || (phase_q == PH_READY);

	// one base tick of a microsecond wait
	assign pre_inc  = pre_q + 8'd1;
	assign us_tick  = (pre_inc >= tpu_eff);
	assign wait_dec = (wait_q != '0) ? wait_q - 1'b1 : wait_q;
	assign cu_pre   = us_tick ? 8'd0 : pre_inc;
	assign cu_wait  = us_tick ? wait_dec : wait_q;
	assign cu_done  = (cu_wait == '0);
	assign step_inc = step_q + 3'd1;

	always_comb begin
		phase_n = phase_q;
		step_n  = step_q;
		pre_n   = pre_q;
		wait_n  = wait_q;
		bus_n   = bus_q;
		sel_n   = sel_q;
		rw_n    = rw_q;
		rej     = 1'b0;
		if (idle) begin
			case (item.act)
				ACT_START: begin
					bus_n   = '0;
					sel_n   = 1'b0;
					rw_n    = 1'b0;
					step_n  = '0;
					pre_n   = '0;
					wait_n  = POWERUP_US;
					phase_n = PH_POWERUP;
				end
				ACT_CMD, ACT_DATA: begin
					bus_n   = item.byte_val;
					sel_n   = (item.act == ACT_DATA);
					rw_n    = 1'b0;
					pre_n   = '0;
					wait_n  = WAIT_W'(eht_eff);
					phase_n = PH_STROBE;
				end
				default: ;
			endcase
		end else begin
			rej = (item.act != ACT_TICK);
			case (phase_q)
				PH_POWERUP: begin
					pre_n  = cu_pre;
					wait_n = cu_wait;
					if (cu_done) begin
						step_n  = '0;
						bus_n   = init_cmd(3'd0);
						sel_n   = 1'b0;
						rw_n    = 1'b0;
						pre_n   = '0;
						wait_n  = WAIT_W'(eht_eff);
						phase_n = PH_INIT_STROBE;
					end
				end
				PH_STROBE, PH_INIT_STROBE: begin
					wait_n = wait_dec;
					// E falls: drop RS, raise RW, load the settle wait
					if (wait_dec == '0) begin
						sel_n = 1'b0;
						rw_n  = 1'b1;
						pre_n = '0;
						if (phase_q == PH_STROBE) begin
							phase_n = PH_SETTLE;
							wait_n  = WAIT_W'(wwu_eff);
						end else begin
							phase_n = PH_INIT_SETTLE;
							wait_n  = init_wait(step_q);
						end
					end
				end
				PH_SETTLE: begin
					pre_n  = cu_pre;
					wait_n = cu_wait;
					if (cu_done) begin
						phase_n = PH_READY;
					end
				end
				PH_INIT_SETTLE: begin
					pre_n  = cu_pre;
					wait_n = cu_wait;
					if (cu_done) begin
						if (step_inc < INIT_CMDS) begin
							step_n  = step_inc;
							bus_n   = init_cmd(step_inc);
							sel_n   = 1'b0;
							rw_n    = 1'b0;
							pre_n   = '0;
							wait_n  = WAIT_W'(eht_eff);
							phase_n = PH_INIT_STROBE;
						end else begin
							step_n  = '0;
							phase_n = PH_READY;
						end
					end
				end
				default: phase_n = PH_UNINIT;
			endcase
		end
	end

	always_comb begin
		res.rs       = sel_n;
		res.rw       = rw_n;
		res.en       = (phase_n == PH_STROBE) || (phase_n == PH_INIT_STROBE);
		res.data     = bus_n;
		res.busy     = !((phase_n == PH_UNINIT) || (phase_n == PH_READY));
		res.rejected = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q   <= TICKS_PER_US_RST;
			eht_q   <= ENABLE_HIGH_RST;
			wwu_q   <= WRITE_WAIT_RST;
			phase_q <= PH_UNINIT;
			step_q  <= '0;
			pre_q   <= '0;
			wait_q  <= '0;
			bus_q   <= '0;
			sel_q   <= 1'b0;
			rw_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_TICKS_PER_US: tpu_q <= cfg_data[7:0];
					REG_ENABLE_HIGH:  eht_q <= cfg_data[7:0];
					REG_WRITE_WAIT:   wwu_q <= cfg_data;
					default: ;
				endcase
			end
			if (fire) begin
				phase_q <= phase_n;
				step_q  <= step_n;
				pre_q   <= pre_n;
				wait_q  <= wait_n;
				bus_q   <= bus_n;
				sel_q   <= sel_n;
				rw_q    <= rw_n;
			end
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q < INIT_CMDS)
		else $error("init step out of range");

	a_strobe_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_STROBE || phase_q == PH_INIT_STROBE) |-> wait_q != '0)
		else $error("strobe phase with empty count");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(phase_q) && $stable(wait_q) && $stable(pre_q))
		else $error("state moved without a word");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		fire && idle && item.act == ACT_START
		|=> phase_q == PH_POWERUP && wait_q == POWERUP_US)
		else $error("start did not load power-up wait");

endmodule

// ----- rtl/core/lcdw_resq.sv -----
module lcdw_resq import lcdw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_push,
	input  result_t res_in,
	output logic    res_full,
	output logic    empty,
	input  logic    pop,
	output result_t res_out
);

	result_t          q_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign res_full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign res_out  = q_mem[rd_ptr_q];
	assign do_push  = res_push && !res_full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
